@@ hdl/stt_pkg.sv @@
package stt_pkg;

  // Identifier matching
  localparam int MAX_KEYWORD_LEN = 8;
  localparam int NKW             = 12;
  localparam int KW_LEN_W        = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int KW_IDX_W        = $clog2(MAX_KEYWORD_LEN);

  // Byte position counter
  localparam int OFFSET_BITS = 32;

  // Result queue, a power of two
  localparam int FIFO_DEPTH = 4;

  // Field widths
  localparam int KIND_W = 5;
  localparam int START_W = 32;
  localparam int LEN_W  = 16;
  localparam int LINE_W = 24;
  localparam int COL_W  = 16;
  localparam int CH_W   = 8;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_NEWLINE  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_HASH     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_STRING   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd17;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_LBRACE   = 5'd19;
  localparam logic [KIND_W-1:0] KIND_RBRACE   = 5'd20;
  localparam logic [KIND_W-1:0] KIND_DOT      = 5'd21;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd22;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 5'd23;
  localparam logic [KIND_W-1:0] KIND_EOF      = 5'd24;

  // Keyword spellings, character j of keyword i at [i][j]
  localparam logic [NKW-1:0][MAX_KEYWORD_LEN-1:0][7:0] KW_TEXT = '{
    0:  '{0:"v", 1:"a", 2:"r", default:8'h00},
    1:  '{0:"f", 1:"u", 2:"n", 3:"c", 4:"t", 5:"i", 6:"o", 7:"n", default:8'h00},
    2:  '{0:"i", 1:"f", default:8'h00},
    3:  '{0:"e", 1:"l", 2:"i", 3:"f", default:8'h00},
    4:  '{0:"e", 1:"l", 2:"s", 3:"e", default:8'h00},
    5:  '{0:"f", 1:"o", 2:"r", default:8'h00},
    6:  '{0:"w", 1:"h", 2:"i", 3:"l", 4:"e", default:8'h00},
    7:  '{0:"r", 1:"e", 2:"t", 3:"u", 4:"r", 5:"n", default:8'h00},
    8:  '{0:"e", 1:"n", 2:"d", default:8'h00},
    9:  '{0:"e", 1:"m", 2:"b", 3:"e", 4:"d", default:8'h00},
    10: '{0:"e", 1:"n", 2:"d", 3:"e", 4:"m", 5:"b", 6:"e", 7:"d", default:8'h00},
    11: '{0:"u", 1:"i", default:8'h00}
  };

  localparam logic [NKW-1:0][KW_LEN_W-1:0] KW_LEN = '{
    0: KW_LEN_W'(3), 1: KW_LEN_W'(8), 2: KW_LEN_W'(2), 3: KW_LEN_W'(4),
    4: KW_LEN_W'(4), 5: KW_LEN_W'(3), 6: KW_LEN_W'(5), 7: KW_LEN_W'(6),
    8: KW_LEN_W'(3), 9: KW_LEN_W'(5), 10: KW_LEN_W'(8), 11: KW_LEN_W'(2)
  };

  // Lexer modes
  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_STRING  = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_IDENT   = 6'b001000,
    M_OP      = 6'b010000,
    M_COMMENT = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start_offset;
    logic [LEN_W-1:0]   length;
    logic [LINE_W-1:0]  line_number;
    logic [COL_W-1:0]   column_number;
    logic [CH_W-1:0]    op_char;
    logic               op_has_equals;
    logic               last;
  } rec_t;

  // Up to two records per accepted byte; v1 only with v0
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } push_t;

endpackage

@@ hdl/stt_chan_if.sv @@
interface stt_in_if;
  logic                     valid;
  logic                     ready;
  logic [stt_pkg::CH_W-1:0] ch;
  logic                     end_of_source;

  modport source (output valid, ch, end_of_source, input ready);
  modport sink   (input valid, ch, end_of_source, output ready);
endinterface

interface stt_out_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::KIND_W-1:0]  kind;
  logic [stt_pkg::START_W-1:0] start_offset;
  logic [stt_pkg::LEN_W-1:0]   length;
  logic [stt_pkg::LINE_W-1:0]  line_number;
  logic [stt_pkg::COL_W-1:0]   column_number;
  logic [stt_pkg::CH_W-1:0]    op_char;
  logic                        op_has_equals;
  logic                        last;

  modport source (output valid, kind, start_offset, length, line_number, column_number,
                  op_char, op_has_equals, last, input ready);
  modport sink   (input valid, kind, start_offset, length, line_number, column_number,
                  op_char, op_has_equals, last, output ready);
endinterface

@@ hdl/stt_lex_core.sv @@
module stt_lex_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [stt_pkg::CH_W-1:0] ch,
  input  logic                     end_of_source,
  output stt_pkg::push_t           push
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  stt_pkg::mode_t                     mode_r, mode_nxt;
  logic [7:0]                         quote_r, quote_nxt;
  logic                               esc_r, esc_nxt;
  logic [stt_pkg::NKW-1:0]            cand_r, cand_nxt;
  logic [7:0]                         pop_r, pop_nxt;
  logic [stt_pkg::LINE_W-1:0]         line_r, line_nxt;
  logic [stt_pkg::COL_W-1:0]          col_r, col_nxt;
  logic [stt_pkg::OFFSET_BITS-1:0]    off_r, off_nxt;
  logic [stt_pkg::OFFSET_BITS-1:0]    tstart_r, tstart_nxt;
  logic [stt_pkg::LINE_W-1:0]         tline_r, tline_nxt;
  logic [stt_pkg::COL_W-1:0]          tcol_r, tcol_nxt;
  logic [stt_pkg::LEN_W-1:0]          tlen_r, tlen_nxt;

  logic         flush_v;
  stt_pkg::rec_t flush_rec;
  logic         va, vb, handled;
  stt_pkg::rec_t ra, rb;

  function automatic stt_pkg::rec_t mk_rec(
    logic [stt_pkg::KIND_W-1:0]      kind,
    logic [stt_pkg::OFFSET_BITS-1:0] start,
    logic [stt_pkg::LEN_W-1:0]       len,
    logic [stt_pkg::LINE_W-1:0]      line,
    logic [stt_pkg::COL_W-1:0]       col,
    logic [7:0]                      opc,
    logic                            opeq
  );
    stt_pkg::rec_t r;
    r.kind          = kind;
    r.start_offset  = stt_pkg::START_W'(start);
    r.length        = len;
    r.line_number   = line;
    r.column_number = col;
    r.op_char       = opc;
    r.op_has_equals = opeq;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_id_cont(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           is_digit(c) || (c == "_");
  endfunction

  // Drop every keyword whose next character differs or which is already used up
  function automatic logic [stt_pkg::NKW-1:0] kw_filter(
    logic [stt_pkg::NKW-1:0]   cand,
    logic [stt_pkg::LEN_W-1:0] len,
    logic [7:0]                c
  );
    logic [stt_pkg::NKW-1:0] res;
    res = cand;
    for (int i = 0; i < stt_pkg::NKW; i++) begin
      if (len >= stt_pkg::LEN_W'(stt_pkg::KW_LEN[i])) begin
        res[i] = 1'b0;
      end else if (stt_pkg::KW_TEXT[i][len[stt_pkg::KW_IDX_W-1:0]] != c) begin
        res[i] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [stt_pkg::KIND_W-1:0] ident_kind(
    logic [stt_pkg::NKW-1:0]   cand,
    logic [stt_pkg::LEN_W-1:0] len
  );
    logic [stt_pkg::KIND_W-1:0] k;
    k = stt_pkg::KIND_IDENT;
    for (int i = 0; i < stt_pkg::NKW; i++) begin
      if (cand[i] && (len == stt_pkg::LEN_W'(stt_pkg::KW_LEN[i]))) begin
        k = stt_pkg::KIND_W'(stt_pkg::KIND_KEYWORD0 + i);
      end
    end
    return k;
  endfunction

  function automatic logic [stt_pkg::COL_W-1:0] col_inc(logic [stt_pkg::COL_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Record for whatever token is open
  always_comb begin
    flush_v   = 1'b1;
    flush_rec = mk_rec(stt_pkg::KIND_STRING, tstart_r, tlen_r, tline_r, tcol_r, 8'h00, 1'b0);
    unique case (mode_r)
      stt_pkg::M_STRING: begin
        flush_rec.kind = stt_pkg::KIND_STRING;
      end
      stt_pkg::M_NUMBER: begin
        flush_rec.kind = stt_pkg::KIND_NUMBER;
      end
      stt_pkg::M_IDENT: begin
        flush_rec.kind = ident_kind(cand_r, tlen_r);
      end
      stt_pkg::M_OP: begin
        flush_rec.kind    = stt_pkg::KIND_OPERATOR;
        flush_rec.length  = stt_pkg::LEN_W'(1);
        flush_rec.op_char = pop_r;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    quote_nxt  = quote_r;
    esc_nxt    = esc_r;
    cand_nxt   = cand_r;
    pop_nxt    = pop_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    off_nxt    = off_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    tlen_nxt   = tlen_r;
    va         = 1'b0;
    vb         = 1'b0;
    ra         = flush_rec;
    rb         = flush_rec;
    handled    = 1'b1;

    if (end_of_source) begin
      // Flush, then end-of-file, then back to the reset state
      va         = flush_v;
      vb         = 1'b1;
      rb         = mk_rec(stt_pkg::KIND_EOF, off_r, '0, line_r, col_r, 8'h00, 1'b0);
      mode_nxt   = stt_pkg::M_IDLE;
      quote_nxt  = '0;
      esc_nxt    = 1'b0;
      cand_nxt   = '1;
      pop_nxt    = '0;
      line_nxt   = stt_pkg::LINE_W'(1);
      col_nxt    = stt_pkg::COL_W'(1);
      off_nxt    = '0;
      tstart_nxt = '0;
      tline_nxt  = '0;
      tcol_nxt   = '0;
      tlen_nxt   = '0;
    end else begin
      unique case (mode_r)
        stt_pkg::M_STRING: begin
          if (esc_r) begin
            esc_nxt  = 1'b0;
            tlen_nxt = (tlen_r == '1) ? tlen_r : tlen_r + 1'b1;
          end else if (ch == quote_r) begin
            va       = 1'b1;
            mode_nxt = stt_pkg::M_IDLE;
            esc_nxt  = 1'b0;
            pop_nxt  = '0;
            cand_nxt = '1;
          end else begin
            if (ch == CH_BSL) begin
              esc_nxt = 1'b1;
            end
            tlen_nxt = (tlen_r == '1) ? tlen_r : tlen_r + 1'b1;
          end
          off_nxt = off_r + 1'b1;
          col_nxt = col_inc(col_r);
        end
        stt_pkg::M_COMMENT: begin
          if (ch == CH_LF) begin
            mode_nxt = stt_pkg::M_IDLE;
            handled  = 1'b0;
          end else begin
            off_nxt = off_r + 1'b1;
            col_nxt = col_inc(col_r);
          end
        end
        stt_pkg::M_NUMBER: begin
          if (is_digit(ch) || (ch == ".")) begin
            tlen_nxt = (tlen_r == '1) ? tlen_r : tlen_r + 1'b1;
            off_nxt  = off_r + 1'b1;
            col_nxt  = col_inc(col_r);
          end else begin
            va       = 1'b1;
            mode_nxt = stt_pkg::M_IDLE;
            esc_nxt  = 1'b0;
            pop_nxt  = '0;
            cand_nxt = '1;
            handled  = 1'b0;
          end
        end
        stt_pkg::M_IDENT: begin
          if (is_id_cont(ch)) begin
            cand_nxt = kw_filter(cand_r, tlen_r, ch);
            tlen_nxt = (tlen_r == '1) ? tlen_r : tlen_r + 1'b1;
            off_nxt  = off_r + 1'b1;
            col_nxt  = col_inc(col_r);
          end else begin
            va       = 1'b1;
            mode_nxt = stt_pkg::M_IDLE;
            esc_nxt  = 1'b0;
            pop_nxt  = '0;
            cand_nxt = '1;
            handled  = 1'b0;
          end
        end
        stt_pkg::M_OP: begin
          if (ch == "=") begin
            va       = 1'b1;
            ra       = mk_rec(stt_pkg::KIND_OPERATOR, tstart_r, stt_pkg::LEN_W'(2),
                              tline_r, tcol_r, pop_r, 1'b1);
            mode_nxt = stt_pkg::M_IDLE;
            pop_nxt  = '0;
            off_nxt  = off_r + 1'b1;
            col_nxt  = col_inc(col_r);
          end else if ((pop_r == "/") && (ch == "/")) begin
            mode_nxt = stt_pkg::M_COMMENT;
            pop_nxt  = '0;
            off_nxt  = off_r + 1'b1;
            col_nxt  = col_inc(col_r);
          end else begin
            va       = 1'b1;
            mode_nxt = stt_pkg::M_IDLE;
            esc_nxt  = 1'b0;
            pop_nxt  = '0;
            cand_nxt = '1;
            handled  = 1'b0;
          end
        end
        default: begin
          handled = 1'b0;
        end
      endcase

      // Byte that starts afresh, seen with the state left above
      if (!handled) begin
        rb = mk_rec(stt_pkg::KIND_HASH, off_nxt, stt_pkg::LEN_W'(1), line_nxt, col_nxt,
                    8'h00, 1'b0);
        case (ch) inside
          CH_SPACE, CH_TAB, CH_CR: begin
            off_nxt = off_nxt + 1'b1;
            col_nxt = col_inc(col_nxt);
          end
          CH_LF: begin
            vb       = 1'b1;
            rb.kind  = stt_pkg::KIND_NEWLINE;
            off_nxt  = off_nxt + 1'b1;
            line_nxt = (line_nxt == '1) ? line_nxt : line_nxt + 1'b1;
            col_nxt  = stt_pkg::COL_W'(1);
          end
          "#": begin
            vb      = 1'b1;
            off_nxt = off_nxt + 1'b1;
            col_nxt = col_inc(col_nxt);
          end
          "\"", "'": begin
            tline_nxt  = line_nxt;
            tcol_nxt   = col_nxt;
            off_nxt    = off_nxt + 1'b1;
            col_nxt    = col_inc(col_nxt);
            tstart_nxt = off_nxt;
            tlen_nxt   = '0;
            mode_nxt   = stt_pkg::M_STRING;
            quote_nxt  = ch;
            esc_nxt    = 1'b0;
          end
          ["0":"9"]: begin
            mode_nxt   = stt_pkg::M_NUMBER;
            tstart_nxt = off_nxt;
            tline_nxt  = line_nxt;
            tcol_nxt   = col_nxt;
            tlen_nxt   = stt_pkg::LEN_W'(1);
            off_nxt    = off_nxt + 1'b1;
            col_nxt    = col_inc(col_nxt);
          end
          ["a":"z"], ["A":"Z"], "_": begin
            mode_nxt   = stt_pkg::M_IDENT;
            tstart_nxt = off_nxt;
            tline_nxt  = line_nxt;
            tcol_nxt   = col_nxt;
            cand_nxt   = kw_filter('1, '0, ch);
            tlen_nxt   = stt_pkg::LEN_W'(1);
            off_nxt    = off_nxt + 1'b1;
            col_nxt    = col_inc(col_nxt);
          end
          "(", ")", "{", "}", ".", ",": begin
            vb = 1'b1;
            case (ch)
              "(":     rb.kind = stt_pkg::KIND_LPAREN;
              ")":     rb.kind = stt_pkg::KIND_RPAREN;
              "{":     rb.kind = stt_pkg::KIND_LBRACE;
              "}":     rb.kind = stt_pkg::KIND_RBRACE;
              ".":     rb.kind = stt_pkg::KIND_DOT;
              default: rb.kind = stt_pkg::KIND_COMMA;
            endcase
            off_nxt = off_nxt + 1'b1;
            col_nxt = col_inc(col_nxt);
          end
          "+", "-", "*", "/", "=", "<", ">", "!": begin
            mode_nxt   = stt_pkg::M_OP;
            tstart_nxt = off_nxt;
            tline_nxt  = line_nxt;
            tcol_nxt   = col_nxt;
            pop_nxt    = ch;
            tlen_nxt   = stt_pkg::LEN_W'(1);
            off_nxt    = off_nxt + 1'b1;
            col_nxt    = col_inc(col_nxt);
          end
          default: begin
            off_nxt = off_nxt + 1'b1;
            col_nxt = col_inc(col_nxt);
          end
        endcase
      end
    end
  end

  // Pack records into slot order; mark the final one
  always_comb begin
    push.v0 = accept && (va || vb);
    push.v1 = accept && va && vb;
    push.r0 = va ? ra : rb;
    push.r1 = rb;
    push.r0.last = !(va && vb);
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stt_pkg::M_IDLE;
      quote_r  <= '0;
      esc_r    <= 1'b0;
      cand_r   <= '1;
      pop_r    <= '0;
      line_r   <= stt_pkg::LINE_W'(1);
      col_r    <= stt_pkg::COL_W'(1);
      off_r    <= '0;
      tstart_r <= '0;
      tline_r  <= '0;
      tcol_r   <= '0;
      tlen_r   <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      quote_r  <= quote_nxt;
      esc_r    <= esc_nxt;
      cand_r   <= cand_nxt;
      pop_r    <= pop_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      off_r    <= off_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
      tlen_r   <= tlen_nxt;
    end
  end

endmodule

@@ hdl/stt_out_fifo.sv @@
module stt_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  stt_pkg::push_t push,
  input  logic           pop,
  output stt_pkg::rec_t  head,
  output logic           head_valid,
  output logic           room
);

  localparam int PTR_W = $clog2(stt_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(stt_pkg::FIFO_DEPTH + 1);

  stt_pkg::rec_t mem_r [stt_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_nxt, wr_plus1;
  logic [CNT_W-1:0] n_wr;

  always_comb begin
    wr_plus1 = wr_r + 1'b1;
    n_wr     = CNT_W'(push.v0) + CNT_W'(push.v1);
    wr_nxt   = wr_r + PTR_W'(n_wr);
    cnt_nxt  = cnt_r + n_wr - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_plus1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  assign head       = mem_r[rd_r];
  assign head_valid = (cnt_r != '0);
  // Leave space for the two records one byte can produce
  assign room       = (cnt_r <= CNT_W'(stt_pkg::FIFO_DEPTH - 2));

endmodule

@@ hdl/source_text_tokenizer.sv @@
// Channel   Dir  Transaction
// --------  ---  -----------------------------------------------------------
// in_chan   in   one source byte (ch) or an end marker (end_of_source)
// out_chan  out  one token record: kind, offsets, line/column, operator info
//
// Each byte is lexed in the cycle it is accepted; its records are in the
// result queue from the next cycle and reach out_chan behind any older records.
// One input transaction per cycle while the queue has room for two records, so
// the rate is one byte per cycle, limited by out_chan stalls and by the output
// taking one record per cycle when a byte yields two (a token ended plus one).
// Reset is synchronous on rst_n and leaves the lexer at line 1, column 1.
// A stall on out_chan drops in_chan.ready once three of the four queue
// entries are taken, so a byte with two records can still fill the queue.
module source_text_tokenizer (
  input logic        clk,
  input logic        rst_n,
  stt_in_if.sink     in_chan,
  stt_out_if.source  out_chan
);

  stt_pkg::push_t push;
  stt_pkg::rec_t  head;
  logic           head_valid;
  logic           room;
  logic           in_accept;
  logic           out_pop;

  // Accept a byte only when both of its possible records fit
  assign in_chan.ready = room;
  assign in_accept     = in_chan.valid && room;
  assign out_pop       = head_valid && out_chan.ready;

  // Lexer state and per-byte decode
  stt_lex_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .ch            (in_chan.ch),
    .end_of_source (in_chan.end_of_source),
    .push          (push)
  );

  // Result queue: two writes, one read per cycle
  stt_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  // Drive the result channel straight from the queue head
  assign out_chan.valid         = head_valid;
  assign out_chan.kind          = head.kind;
  assign out_chan.start_offset  = head.start_offset;
  assign out_chan.length        = head.length;
  assign out_chan.line_number   = head.line_number;
  assign out_chan.column_number = head.column_number;
  assign out_chan.op_char       = head.op_char;
  assign out_chan.op_has_equals = head.op_has_equals;
  assign out_chan.last          = head.last;

endmodule

@@ tb/source_text_tokenizer_tb.sv @@
module source_text_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte codes that have no printable literal of their own
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_DQUOTE = 8'h22;
  localparam logic [7:0] BYTE_SQUOTE = 8'h27;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;

  localparam int RANDOM_ITEMS = 1100;  // stop the random text here
  localparam int HOLD_CYCLES  = 48;    // long output stall, well past the queue depth

  typedef struct packed {
    logic [stt_pkg::CH_W-1:0] ch;
    logic                     end_of_source;
  } text_item_t;

  logic clk;
  logic rst_n;

  stt_in_if  in_chan();
  stt_out_if out_chan();

  source_text_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  text_item_t    pending_text[$];    // bytes still to be offered
  stt_pkg::rec_t expected_tokens[$]; // token records predicted but not yet seen
  int            items_sent;
  int            fail_count;

  // Keyword spellings in kind order, starting at KIND_KEYWORD0
  string kw_names[stt_pkg::NKW] = '{"var", "function", "if", "elif", "else", "for",
                                    "while", "return", "end", "embed", "endembed", "ui"};
  // Identifier bytes; the first 53 may also start one
  string id_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string op_chars = "+-*/=<>!";

  // ---------------------------------------------------------------------------
  // Lexer prediction: a shadow copy of the tokenizer state, advanced once per
  // accepted input transaction.
  // ---------------------------------------------------------------------------
  stt_pkg::mode_t              lx_mode;
  logic [7:0]                  lx_quote;
  logic                        lx_escape;
  logic [stt_pkg::NKW-1:0]     lx_cands;   // keywords still matching the open identifier
  logic [7:0]                  lx_pend_op;
  logic [stt_pkg::LINE_W-1:0]  lx_line;
  logic [stt_pkg::COL_W-1:0]   lx_col;
  logic [stt_pkg::START_W-1:0] lx_offset;
  logic [stt_pkg::START_W-1:0] tok_start;
  logic [stt_pkg::LINE_W-1:0]  tok_line;
  logic [stt_pkg::COL_W-1:0]   tok_col;
  logic [stt_pkg::LEN_W-1:0]   tok_len;

  stt_pkg::rec_t step_out[2];   // records caused by the current byte
  int            step_n;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_id_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" ||
           c == "=" || c == "<" || c == ">" || c == "!";
  endfunction

  function void reset_lexer();
    lx_mode    = stt_pkg::M_IDLE;
    lx_quote   = '0;
    lx_escape  = 1'b0;
    lx_cands   = '1;
    lx_pend_op = '0;
    lx_line    = stt_pkg::LINE_W'(1);
    lx_col     = stt_pkg::COL_W'(1);
    lx_offset  = '0;
    tok_start  = '0;
    tok_line   = '0;
    tok_col    = '0;
    tok_len    = '0;
  endfunction

  function void add_token(logic [stt_pkg::KIND_W-1:0] kind,
                          logic [stt_pkg::START_W-1:0] start,
                          logic [stt_pkg::LEN_W-1:0] len, logic [stt_pkg::LINE_W-1:0] line,
                          logic [stt_pkg::COL_W-1:0] col, logic [7:0] opc, logic opeq);
    stt_pkg::rec_t r;
    if (step_n >= 2) return;
    r.kind          = kind;
    r.start_offset  = start;
    r.length        = len;
    r.line_number   = line;
    r.column_number = col;
    r.op_char       = opc;
    r.op_has_equals = opeq;
    r.last          = 1'b0;
    step_out[step_n] = r;
    step_n++;
  endfunction

  // Advance one byte position on the current line; the column saturates
  function void bump_column();
    lx_offset++;
    if (lx_col != '1) lx_col++;
  endfunction

  function void grow_len();
    if (tok_len != '1) tok_len++;
  endfunction

  function void open_token(stt_pkg::mode_t m);
    lx_mode   = m;
    tok_start = lx_offset;
    tok_line  = lx_line;
    tok_col   = lx_col;
    tok_len   = '0;
  endfunction

  // Drop every keyword that the byte at position tok_len rules out
  function void filter_kw(logic [7:0] c);
    for (int i = 0; i < stt_pkg::NKW; i++)
      if (lx_cands[i] && (int'(tok_len) >= kw_names[i].len() || kw_names[i][tok_len] != c))
        lx_cands[i] = 1'b0;
  endfunction

  // Emit whatever token is open and fall back to idle
  function void flush_token();
    logic [stt_pkg::KIND_W-1:0] kind;
    case (lx_mode)
      stt_pkg::M_STRING:
        add_token(stt_pkg::KIND_STRING, tok_start, tok_len, tok_line, tok_col, '0, 1'b0);
      stt_pkg::M_NUMBER:
        add_token(stt_pkg::KIND_NUMBER, tok_start, tok_len, tok_line, tok_col, '0, 1'b0);
      stt_pkg::M_IDENT: begin
        kind = stt_pkg::KIND_IDENT;
        for (int i = 0; i < stt_pkg::NKW; i++)
          if (lx_cands[i] && int'(tok_len) == kw_names[i].len())
            kind = stt_pkg::KIND_W'(stt_pkg::KIND_KEYWORD0 + i);
        add_token(kind, tok_start, tok_len, tok_line, tok_col, '0, 1'b0);
      end
      stt_pkg::M_OP:
        add_token(stt_pkg::KIND_OPERATOR, tok_start, stt_pkg::LEN_W'(1), tok_line, tok_col,
                  lx_pend_op, 1'b0);
      default: ;
    endcase
    lx_mode    = stt_pkg::M_IDLE;
    lx_escape  = 1'b0;
    lx_pend_op = '0;
    lx_cands   = '1;
  endfunction

  // Advance the shadow lexer by one accepted byte or end marker and queue the
  // records that it causes, marking the final one.
  task automatic lex_item(input logic [7:0] c, input logic eos);
    bit                         handled;
    bit                         punct;
    logic [stt_pkg::KIND_W-1:0] pk;
    int                         i;
    step_n = 0;
    if (eos) begin
      flush_token();
      add_token(stt_pkg::KIND_EOF, lx_offset, '0, lx_line, lx_col, '0, 1'b0);
      reset_lexer();
    end else begin
      handled = 1'b1;
      case (lx_mode)
        stt_pkg::M_STRING: begin
          if (lx_escape) begin
            lx_escape = 1'b0;
            grow_len();
          end else if (c == lx_quote) begin
            flush_token();
          end else begin
            if (c == BYTE_BSLASH) lx_escape = 1'b1;
            grow_len();
          end
          bump_column();
        end
        stt_pkg::M_COMMENT: begin
          // the line feed that ends a comment is still a newline token
          if (c == BYTE_LF) begin
            lx_mode = stt_pkg::M_IDLE;
            handled = 1'b0;
          end else begin
            bump_column();
          end
        end
        stt_pkg::M_NUMBER: begin
          if (is_digit(c) || c == ".") begin
            grow_len();
            bump_column();
          end else begin
            flush_token();
            handled = 1'b0;
          end
        end
        stt_pkg::M_IDENT: begin
          if (is_id_start(c) || is_digit(c)) begin
            filter_kw(c);
            grow_len();
            bump_column();
          end else begin
            flush_token();
            handled = 1'b0;
          end
        end
        stt_pkg::M_OP: begin
          if (c == "=") begin
            add_token(stt_pkg::KIND_OPERATOR, tok_start, stt_pkg::LEN_W'(2), tok_line, tok_col,
                      lx_pend_op, 1'b1);
            lx_mode    = stt_pkg::M_IDLE;
            lx_pend_op = '0;
            bump_column();
          end else if (lx_pend_op == "/" && c == "/") begin
            lx_mode    = stt_pkg::M_COMMENT;
            lx_pend_op = '0;
            bump_column();
          end else begin
            flush_token();
            handled = 1'b0;
          end
        end
        default: handled = 1'b0;
      endcase

      // Byte seen from idle, either fresh or left over from a closed token
      if (!handled) begin
        if (c == " " || c == BYTE_TAB || c == BYTE_CR) begin
          bump_column();
        end else if (c == BYTE_LF) begin
          add_token(stt_pkg::KIND_NEWLINE, lx_offset, stt_pkg::LEN_W'(1), lx_line, lx_col,
                    '0, 1'b0);
          lx_offset++;
          if (lx_line != '1) lx_line++;
          lx_col = stt_pkg::COL_W'(1);
        end else if (c == "#") begin
          add_token(stt_pkg::KIND_HASH, lx_offset, stt_pkg::LEN_W'(1), lx_line, lx_col,
                    '0, 1'b0);
          bump_column();
        end else if (c == BYTE_DQUOTE || c == BYTE_SQUOTE) begin
          // position is the quote's, offset the first content byte's
          tok_line = lx_line;
          tok_col  = lx_col;
          bump_column();
          tok_start = lx_offset;
          tok_len   = '0;
          lx_mode   = stt_pkg::M_STRING;
          lx_quote  = c;
          lx_escape = 1'b0;
        end else if (is_digit(c)) begin
          open_token(stt_pkg::M_NUMBER);
          tok_len = stt_pkg::LEN_W'(1);
          bump_column();
        end else if (is_id_start(c)) begin
          open_token(stt_pkg::M_IDENT);
          lx_cands = '1;
          filter_kw(c);
          tok_len = stt_pkg::LEN_W'(1);
          bump_column();
        end else begin
          punct = 1'b1;
          pk    = stt_pkg::KIND_LPAREN;
          case (c)
            "(":     pk = stt_pkg::KIND_LPAREN;
            ")":     pk = stt_pkg::KIND_RPAREN;
            "{":     pk = stt_pkg::KIND_LBRACE;
            "}":     pk = stt_pkg::KIND_RBRACE;
            ".":     pk = stt_pkg::KIND_DOT;
            ",":     pk = stt_pkg::KIND_COMMA;
            default: punct = 1'b0;
          endcase
          if (punct) begin
            add_token(pk, lx_offset, stt_pkg::LEN_W'(1), lx_line, lx_col, '0, 1'b0);
            bump_column();
          end else if (is_op(c)) begin
            open_token(stt_pkg::M_OP);
            lx_pend_op = c;
            tok_len    = stt_pkg::LEN_W'(1);
            bump_column();
          end else begin
            // starts no token: just move along the line
            bump_column();
          end
        end
      end
    end

    if (step_n > 0) step_out[step_n-1].last = 1'b1;
    for (i = 0; i < step_n; i++) expected_tokens.push_back(step_out[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Traffic shaping: sender idles lightly then heavily, receiver the reverse,
  // then both run flat out.
  // ---------------------------------------------------------------------------
  function automatic int traffic_phase();
    if (items_sent < 370) return 0;
    if (items_sent < 740) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (traffic_phase())
      0:       return 20;
      1:       return 69;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (traffic_phase())
      0:       return 69;
      1:       return 20;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Text building
  // ---------------------------------------------------------------------------
  function void push_byte(logic [7:0] b);
    pending_text.push_back('{ch: b, end_of_source: 1'b0});
  endfunction

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function void push_end();
    // the byte beside an end marker is ignored, so let it roam
    pending_text.push_back('{ch: 8'($urandom_range(255)), end_of_source: 1'b1});
  endfunction

  // One well-formed lexeme with random content, a little noise, or an end marker
  task automatic add_fragment();
    int    pick;
    int    n;
    int    cut;
    string w;
    logic [7:0] q;
    pick = $urandom_range(99);
    if (pick < 16) begin
      // keyword, sometimes cut short or run on into a longer identifier
      w   = kw_names[$urandom_range(stt_pkg::NKW-1)];
      cut = ($urandom_range(3) == 0) ? $urandom_range(1, w.len()) : w.len();
      for (int i = 0; i < cut; i++) push_byte(w[i]);
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) push_byte(id_chars[$urandom_range(62)]);
    end else if (pick < 26) begin
      // plain identifier, long ones included
      push_byte(id_chars[$urandom_range(52)]);
      repeat ($urandom_range(0, 11)) push_byte(id_chars[$urandom_range(62)]);
    end else if (pick < 35) begin
      repeat ($urandom_range(1, 6))
        push_byte(($urandom_range(4) == 0) ? 8'(".") : 8'("0" + $urandom_range(9)));
    end else if (pick < 45) begin
      q = $urandom_range(1) ? BYTE_DQUOTE : BYTE_SQUOTE;
      push_byte(q);
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(9))
          0: begin
            push_byte(BYTE_BSLASH);
            push_byte($urandom_range(1) ? q : 8'($urandom_range(255)));
          end
          1:       push_byte(BYTE_LF);
          2:       push_byte((q == BYTE_DQUOTE) ? BYTE_SQUOTE : BYTE_DQUOTE);
          default: push_byte(id_chars[$urandom_range(62)]);
        endcase
      end
      // leave a few open so that later bytes land inside them
      if ($urandom_range(6) != 0) push_byte(q);
    end else if (pick < 57) begin
      push_byte(op_chars[$urandom_range(7)]);
      if ($urandom_range(4) < 2) push_byte("=");
    end else if (pick < 66) begin
      case ($urandom_range(5))
        0:       push_byte("(");
        1:       push_byte(")");
        2:       push_byte("{");
        3:       push_byte("}");
        4:       push_byte(".");
        default: push_byte(",");
      endcase
    end else if (pick < 78) begin
      case ($urandom_range(2))
        0:       push_byte(" ");
        1:       push_byte(BYTE_TAB);
        default: push_byte(BYTE_CR);
      endcase
    end else if (pick < 84) begin
      push_byte(BYTE_LF);
    end else if (pick < 87) begin
      push_byte("#");
    end else if (pick < 91) begin
      push_text("//");
      repeat ($urandom_range(0, 6)) begin
        q = 8'($urandom_range(255));
        push_byte((q == BYTE_LF) ? 8'("x") : q);
      end
      push_byte(BYTE_LF);
    end else if (pick < 98) begin
      push_byte(8'($urandom_range(255)));
    end else begin
      push_end();
    end
    if ($urandom_range(4) < 2) push_byte(" ");
  endtask

  // ---------------------------------------------------------------------------
  // Clock, and every input held at a known value from time zero
  // ---------------------------------------------------------------------------
  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.ch            = '0;
    in_chan.end_of_source = 1'b0;
    out_chan.ready        = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer bytes from the pending text, predicting each one as its
  // transaction completes. Hold the payload steady while valid waits on ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    text_item_t item;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      reset_lexer();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        lex_item(in_chan.ch, in_chan.end_of_source);
        items_sent++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_text.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          item                  = pending_text.pop_front();
          in_chan.valid         <= 1'b1;
          in_chan.ch            <= item.ch;
          in_chan.end_of_source <= item.end_of_source;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each token transaction against the oldest prediction and
  // drive ready, with two long hold-offs that back the block up into its input.
  // ---------------------------------------------------------------------------
  int hold_left;
  int next_hold;
  int hold_at[2] = '{200, 500};

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : token_monitor
    stt_pkg::rec_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token record with none predicted: kind %0d at offset %0d",
                 out_chan.kind, out_chan.start_offset);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind",          64'(want.kind),          64'(out_chan.kind));
          check_field("start_offset",  64'(want.start_offset),  64'(out_chan.start_offset));
          check_field("length",        64'(want.length),        64'(out_chan.length));
          check_field("line_number",   64'(want.line_number),   64'(out_chan.line_number));
          check_field("column_number", 64'(want.column_number),
                      64'(out_chan.column_number));
          check_field("op_char",       64'(want.op_char),       64'(out_chan.op_char));
          check_field("op_has_equals", 64'(want.op_has_equals),
                      64'(out_chan.op_has_equals));
          check_field("last",          64'(want.last),          64'(out_chan.last));
        end
      end

      if (hold_left == 0 && next_hold < 2 && items_sent >= hold_at[next_hold]) begin
        hold_left = HOLD_CYCLES;
        next_hold++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    items_sent = 0;
    fail_count = 0;
    hold_left  = 0;
    next_hold  = 0;

    // Directed text: joined and lone operators, an operator closed by a hash,
    // both quotes with an escaped quote, a number with a dot, a comment,
    // bytes that start nothing, then an end inside a string with an escape
    // left hanging.
    push_text("x+=9.1 'a\\'b',/#//z\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_text("\"q\\");
    push_end();

    while (pending_text.size() < RANDOM_ITEMS) add_fragment();
    push_end();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Advance until every byte has been taken and every token has come out
    while (pending_text.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    #1ms;
    $display("status: fail");
    $finish;
  end

endmodule
